FILE: rtl/hca_pkg.sv
// ----------------------------------------------------------------------------
// hca_pkg
// Shared types and constants for the HSV color adjust block.
// ----------------------------------------------------------------------------
package hca_pkg;

  localparam logic [24:0] SECTOR_FX = 25'd3932160;
  localparam logic [24:0] FULL_FX   = 25'd23592960;

  localparam int unsigned DIV_W      = 30;
  localparam int unsigned DIV_SPS    = 2;
  localparam int unsigned DIV_STAGES = DIV_W / DIV_SPS;

  localparam int unsigned MID_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    REG_HUE = 2'd0,
    REG_SAT = 2'd1,
    REG_VAL = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BASE_RED   = 2'd0,
    BASE_GREEN = 2'd1,
    BASE_BLUE  = 2'd2
  } base_t;

  typedef struct packed {
    logic signed [8:0] hue;
    logic signed [6:0] sat;
    logic signed [6:0] val;
  } shift_t;

  typedef struct packed {
    logic [24:0] hue;
    logic [16:0] sat;
    logic [7:0]  mx;
    logic        gray;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] mx;
    logic       neg;
    base_t      base;
    logic       gray;
  } div_tag_t;

endpackage

FILE: rtl/hca_fifo.sv
// ----------------------------------------------------------------------------
// hca_fifo
// Small register queue with count based full and empty flags.
// ----------------------------------------------------------------------------
module hca_fifo
  import hca_pkg::*;
#(
  parameter int unsigned DEPTH = MID_DEPTH_DEF,
  parameter int unsigned W     = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

FILE: rtl/hca_div.sv
// ----------------------------------------------------------------------------
// hca_div
// Pipelined restoring divider, two lanes (hue and saturation), 8-bit divisors.
// ----------------------------------------------------------------------------
module hca_div
  import hca_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DIV_W-1:0] num_h,
  input  logic [7:0]       den_h,
  input  logic [DIV_W-1:0] num_s,
  input  logic [7:0]       den_s,
  input  div_tag_t         tag_in,
  output logic             out_valid,
  output logic [DIV_W-1:0] quo_h,
  output logic [DIV_W-1:0] quo_s,
  output div_tag_t         tag_out
);

  function automatic logic [8:0] div_step(logic [7:0] rem, logic nb, logic [7:0] den);
    logic [8:0] t;
    t = {rem, nb};
    if (t >= {1'b0, den}) begin
      div_step = {1'b1, 8'(t - {1'b0, den})};
    end else begin
      div_step = {1'b0, t[7:0]};
    end
  endfunction

  logic [DIV_STAGES:0] vld;
  logic [DIV_W-1:0]    nh [DIV_STAGES+1];
  logic [DIV_W-1:0]    qh [DIV_STAGES+1];
  logic [7:0]          rh [DIV_STAGES+1];
  logic [7:0]          dh [DIV_STAGES+1];
  logic [DIV_W-1:0]    ns [DIV_STAGES+1];
  logic [DIV_W-1:0]    qs [DIV_STAGES+1];
  logic [7:0]          rs [DIV_STAGES+1];
  logic [7:0]          ds [DIV_STAGES+1];
  div_tag_t            tg [DIV_STAGES+1];

  assign vld[0] = in_valid;
  assign nh[0]  = num_h;
  assign qh[0]  = '0;
  assign rh[0]  = '0;
  assign dh[0]  = den_h;
  assign ns[0]  = num_s;
  assign qs[0]  = '0;
  assign rs[0]  = '0;
  assign ds[0]  = den_s;
  assign tg[0]  = tag_in;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_W-1:0] nh_c, qh_c, ns_c, qs_c;
    logic [7:0]       rh_c, rs_c;
    logic [8:0]       sth, sts;

    always_comb begin
      nh_c = nh[k];
      qh_c = qh[k];
      rh_c = rh[k];
      ns_c = ns[k];
      qs_c = qs[k];
      rs_c = rs[k];
      sth  = '0;
      sts  = '0;
      for (int j = 0; j < DIV_SPS; j++) begin
        sth  = div_step(rh_c, nh_c[DIV_W-1], dh[k]);
        rh_c = sth[7:0];
        qh_c = {qh_c[DIV_W-2:0], sth[8]};
        nh_c = {nh_c[DIV_W-2:0], 1'b0};
        sts  = div_step(rs_c, ns_c[DIV_W-1], ds[k]);
        rs_c = sts[7:0];
        qs_c = {qs_c[DIV_W-2:0], sts[8]};
        ns_c = {ns_c[DIV_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nh[k+1] <= nh_c;
        qh[k+1] <= qh_c;
        rh[k+1] <= rh_c;
        dh[k+1] <= dh[k];
        ns[k+1] <= ns_c;
        qs[k+1] <= qs_c;
        rs[k+1] <= rs_c;
        ds[k+1] <= ds[k];
        tg[k+1] <= tg[k];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign quo_h     = qh[DIV_STAGES];
  assign quo_s     = qs[DIV_STAGES];
  assign tag_out   = tg[DIV_STAGES];

endmodule

FILE: rtl/hca_front.sv
// ----------------------------------------------------------------------------
// hca_front
// Accepts pixels, finds max, min and hue sector, divides out hue and
// saturation.
// ----------------------------------------------------------------------------
module hca_front
  import hca_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  pixel_t pix,
  output logic   out_valid,
  output hsv_t   hsv
);

  logic              a_vld;
  pixel_t            a_pix;
  logic              b_vld;
  logic [7:0]        b_mx;
  logic [7:0]        b_d;
  logic signed [8:0] b_x;
  base_t             b_base;

  logic [7:0]        mx_c, mn_c;
  logic signed [8:0] x_c;
  base_t             base_c;
  logic [8:0]        ax9;
  logic [13:0]       t_c;
  div_tag_t          tag_c;
  div_tag_t          tag_o;
  logic [DIV_W-1:0]  qh, qs;
  logic              d_vld;
  logic signed [25:0] basefx, hq;

  always_comb begin
    mx_c = a_pix.red;
    mn_c = a_pix.red;
    if (a_pix.green > mx_c) mx_c = a_pix.green;
    if (a_pix.blue > mx_c) mx_c = a_pix.blue;
    if (a_pix.green < mn_c) mn_c = a_pix.green;
    if (a_pix.blue < mn_c) mn_c = a_pix.blue;
    if (a_pix.blue == mx_c) begin
      base_c = BASE_BLUE;
      x_c    = $signed({1'b0, a_pix.red}) - $signed({1'b0, a_pix.green});
    end else if (a_pix.green == mx_c) begin
      base_c = BASE_GREEN;
      x_c    = $signed({1'b0, a_pix.blue}) - $signed({1'b0, a_pix.red});
    end else begin
      base_c = BASE_RED;
      x_c    = $signed({1'b0, a_pix.green}) - $signed({1'b0, a_pix.blue});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pix  <= pix;
      b_mx   <= mx_c;
      b_d    <= mx_c - mn_c;
      b_x    <= x_c;
      b_base <= base_c;
    end
  end

  // |x| * 60
  assign ax9   = b_x[8] ? 9'(-b_x) : 9'(b_x);
  assign t_c   = {ax9[7:0], 6'b0} - {4'b0, ax9[7:0], 2'b0};
  assign tag_c = '{mx: b_mx, neg: b_x[8], base: b_base, gray: (b_d == 8'd0)};

  hca_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_vld),
    .num_h     ({t_c, 16'b0}),
    .den_h     (b_d),
    .num_s     ({6'b0, b_d, 16'b0}),
    .den_s     (b_mx),
    .tag_in    (tag_c),
    .out_valid (d_vld),
    .quo_h     (qh),
    .quo_s     (qs),
    .tag_out   (tag_o)
  );

  always_comb begin
    case (tag_o.base)
      BASE_GREEN: basefx = $signed({SECTOR_FX, 1'b0});
      BASE_BLUE:  basefx = $signed({SECTOR_FX, 1'b0}) <<< 1;
      default:    basefx = '0;
    endcase
    hq = tag_o.neg ? basefx - $signed({4'b0, qh[21:0]})
                   : basefx + $signed({4'b0, qh[21:0]});
    if (hq < 0) hq = hq + $signed({1'b0, FULL_FX});
    hsv.hue  = tag_o.gray ? '0 : hq[24:0];
    hsv.sat  = tag_o.gray ? '0 : qs[16:0];
    hsv.mx   = tag_o.mx;
    hsv.gray = tag_o.gray;
  end

  assign out_valid = d_vld;

endmodule

FILE: rtl/hca_back.sv
// ----------------------------------------------------------------------------
// hca_back
// Applies the shifts, clamps and wraps, and converts HSV back to RGB.
// ----------------------------------------------------------------------------
module hca_back
  import hca_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  hsv_t   hsv,
  input  shift_t shifts,
  output logic   out_valid,
  output pixel_t pix
);

  localparam logic [22:0] K60 = 23'd4473925;
  localparam logic [20:0] K25 = 21'd1342178;
  localparam logic [16:0] ONE = 17'd65536;

  function automatic logic signed [18:0] pct(logic signed [6:0] x);
    logic [6:0]  a;
    logic [27:0] p;
    a = x[6] ? 7'(-x) : 7'(x);
    p = 28'(a) * 28'(K25);
    pct = x[6] ? -$signed({2'b0, p[27:11]}) : $signed({2'b0, p[27:11]});
  endfunction

  function automatic logic [16:0] clamp_unit(logic signed [18:0] x);
    if (x < 0) begin
      clamp_unit = '0;
    end else if (x > $signed({2'b0, ONE})) begin
      clamp_unit = ONE;
    end else begin
      clamp_unit = x[16:0];
    end
  endfunction

  function automatic logic [7:0] scale255(logic [33:0] p);
    logic [41:0] t;
    t = {p, 8'b0} - {8'b0, p};
    scale255 = t[39:32];
  endfunction

  logic signed [18:0] soff, voff;

  logic [16:0]        v0;
  logic signed [18:0] vsum, ssum;
  logic signed [26:0] hsum;
  logic [24:0]        hue_c;
  logic [2:0]         m_c;
  logic [24:0]        mfx;
  logic [44:0]        p60;
  logic [16:0]        kf;
  logic [33:0]        pb, pc;
  logic [16:0]        kb, kc;
  logic [24:0]        top_c;
  logic [7:0]         a8, b8, c8;
  pixel_t             pix_c;

  logic [5:0]  vld;
  logic [24:0] s1_hue;
  logic [16:0] s1_sat, s1_val;
  logic [2:0]  s2_m, s3_m, s4_m, s5_m;
  logic [21:0] s2_rem;
  logic [16:0] s2_sat, s2_val, s3_sat, s3_val, s4_val;
  logic [15:0] s3_f;
  logic [16:0] s4_ka, s4_kb, s4_kc;
  logic [7:0]  s4_top, s5_top;
  logic        s4_zero, s5_zero;
  logic [33:0] s5_pa, s5_pb, s5_pc;
  pixel_t      s6_pix;

  always_ff @(posedge clk) begin
    soff <= pct(shifts.sat);
    voff <= pct(shifts.val);
  end

  always_comb begin
    v0   = {1'b0, hsv.mx, hsv.mx} + 17'(hsv.mx == 8'hff);
    vsum = $signed({2'b0, v0}) + voff;
    ssum = $signed({2'b0, hsv.sat}) + soff;
    hsum = $signed({2'b0, hsv.hue});
    if (!hsv.gray) begin
      hsum = hsum + $signed({{2{shifts.hue[8]}}, shifts.hue, 16'b0});
    end
    if (hsum < 0) begin
      hsum = hsum + $signed({2'b0, FULL_FX});
    end else if (hsum >= $signed({2'b0, FULL_FX})) begin
      hsum = hsum - $signed({2'b0, FULL_FX});
    end
    hue_c = hsum[24:0];
  end

  always_comb begin
    m_c = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (s1_hue >= 25'(k * SECTOR_FX)) m_c = 3'(k);
    end
    mfx = 25'(m_c * SECTOR_FX);
  end

  assign p60   = 45'(s2_rem) * 45'(K60);
  assign kf    = ONE - {1'b0, s3_f};
  assign pb    = 34'(s3_sat) * 34'({1'b0, s3_f});
  assign pc    = 34'(s3_sat) * 34'(kf);
  assign kb    = ONE - pb[32:16];
  assign kc    = ONE - pc[32:16];
  assign top_c = {s3_val, 8'b0} - {8'b0, s3_val};

  always_comb begin
    a8 = scale255(s5_pa);
    b8 = scale255(s5_pb);
    c8 = scale255(s5_pc);
    case (s5_m)
      3'd0:    pix_c = '{red: s5_top, green: c8, blue: a8};
      3'd1:    pix_c = '{red: b8, green: s5_top, blue: a8};
      3'd2:    pix_c = '{red: a8, green: s5_top, blue: c8};
      3'd3:    pix_c = '{red: a8, green: b8, blue: s5_top};
      3'd4:    pix_c = '{red: c8, green: a8, blue: s5_top};
      default: pix_c = '{red: s5_top, green: a8, blue: b8};
    endcase
    if (s5_zero) pix_c = '{red: s5_top, green: s5_top, blue: s5_top};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hue  <= hue_c;
      s1_sat  <= hsv.gray ? '0 : clamp_unit(ssum);
      s1_val  <= clamp_unit(vsum);
      s2_m    <= m_c;
      s2_rem  <= 22'(s1_hue - mfx);
      s2_sat  <= s1_sat;
      s2_val  <= s1_val;
      s3_f    <= p60[43:28];
      s3_m    <= s2_m;
      s3_sat  <= s2_sat;
      s3_val  <= s2_val;
      s4_ka   <= ONE - s3_sat;
      s4_kb   <= kb;
      s4_kc   <= kc;
      s4_m    <= s3_m;
      s4_val  <= s3_val;
      s4_top  <= top_c[23:16];
      s4_zero <= (s3_sat == '0);
      s5_pa   <= 34'(s4_val) * 34'(s4_ka);
      s5_pb   <= 34'(s4_val) * 34'(s4_kb);
      s5_pc   <= 34'(s4_val) * 34'(s4_kc);
      s5_m    <= s4_m;
      s5_top  <= s4_top;
      s5_zero <= s4_zero;
      s6_pix  <= pix_c;
    end
  end

  assign out_valid = vld[5];
  assign pix       = s6_pix;

endmodule

FILE: rtl/hsv_color_adjust.sv
// ----------------------------------------------------------------------------
// hsv_color_adjust
// RGB to HSV, H/S/V shift, back to RGB; one pixel a clock unless stalled.
// ----------------------------------------------------------------------------
// Input is pipelined: present a pixel on red_in/green_in/blue_in with push
// high; it is taken at an edge where full is low. Results come out of a
// queue: while empty is low the oldest pixel is on red_out/green_out/blue_out
// and pop takes it. Shifts are written on cfg_valid/cfg_ready with cfg_index
// 0 (hue, degrees), 1 (saturation, percent) or 2 (value, percent); cfg_ready
// is always high. The user must make writes only while no pixel is in flight;
// the block does not enforce this. Throughput is one pixel per clock while
// pop keeps up. A pixel passes two front stages, a 15 stage divider (two
// quotient bits per stage), the middle queue, six back stages and the output
// queue. When the receiver stops popping, the output queue fills, the back
// end freezes, the middle queue fills and full rises; nothing is lost. Reset
// empties the queues, clears the valid flags, zeroes the shift registers.
// ----------------------------------------------------------------------------
module hsv_color_adjust
  import hca_pkg::*;
#(
  parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  shift_t shifts;
  logic   mid_full, mid_empty, mid_push, mid_pop;
  logic   out_full, out_push;
  logic   f_vld, b_vld;
  hsv_t   f_hsv, mid_hsv;
  pixel_t b_pix, o_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shifts <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_HUE: shifts.hue <= cfg_data;
        REG_SAT: shifts.sat <= cfg_data[6:0];
        REG_VAL: shifts.val <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign full = mid_full;

  hca_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (!mid_full),
    .in_valid  (push),
    .pix       ('{red: red_in, green: green_in, blue: blue_in}),
    .out_valid (f_vld),
    .hsv       (f_hsv)
  );

  assign mid_push = f_vld && !mid_full;
  assign mid_pop  = !mid_empty && !out_full;

  hca_fifo #(.DEPTH(MID_DEPTH), .W($bits(hsv_t))) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (f_hsv),
    .pop   (mid_pop),
    .dout  (mid_hsv),
    .full  (mid_full),
    .empty (mid_empty)
  );

  hca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (!out_full),
    .in_valid  (mid_pop),
    .hsv       (mid_hsv),
    .shifts    (shifts),
    .out_valid (b_vld),
    .pix       (b_pix)
  );

  assign out_push = b_vld && !out_full;

  hca_fifo #(.DEPTH(OUT_DEPTH), .W($bits(pixel_t))) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (b_pix),
    .pop   (pop && !empty),
    .dout  (o_pix),
    .full  (out_full),
    .empty (empty)
  );

  assign red_out   = o_pix.red;
  assign green_out = o_pix.green;
  assign blue_out  = o_pix.blue;

endmodule

FILE: tb/sv/tb_hsv_color_adjust.sv
// ----------------------------------------------------------------------------
// tb_hsv_color_adjust
// Self-checking bench for the HSV color adjust block: a queue-fed driver
// pushes pixels under several idle/stall phases and shift settings, and a
// monitor compares every popped pixel with an independent fixed-point model.
// ----------------------------------------------------------------------------
module tb_hsv_color_adjust
  import hca_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_FX  = 65536;
  localparam longint SEC_FX  = 3932160;
  localparam longint TURN_FX = 23592960;
  localparam int     DRAIN   = 60;
  localparam longint LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, cfg_ready;
  logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
  logic [7:0] red_out, green_out, blue_out;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  pixel_t pending_pixels[$];
  pixel_t expected_pixels[$];
  logic signed [8:0] hue_offset = '0;
  logic signed [6:0] sat_offset = '0;
  logic signed [6:0] val_offset = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int pixels_checked = 0;
  int pixels_sent = 0;
  longint cycles = 0;

  hsv_color_adjust dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint scale_255(longint v, longint k);
    return (v * k * 255) >>> 32;
  endfunction

  function automatic pixel_t adjust_pixel(pixel_t p);
    longint r, g, b, mx, mn, d, hue, sat, val, top, m, rem, f, a, bb, c;
    pixel_t o;
    r = longint'(p.red);
    g = longint'(p.green);
    b = longint'(p.blue);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    hue = 0;
    sat = 0;
    val = (mx * ONE_FX) / 255 + (longint'(val_offset) * ONE_FX) / 100;
    if (d != 0) begin
      if (b == mx) hue = 4 * SEC_FX + ((r - g) * SEC_FX) / d;
      else if (g == mx) hue = 2 * SEC_FX + ((b - r) * SEC_FX) / d;
      else hue = ((g - b) * SEC_FX) / d;
      if (hue < 0) hue += TURN_FX;
      sat = (d * ONE_FX) / mx;
      hue += longint'(hue_offset) * ONE_FX;
      sat += (longint'(sat_offset) * ONE_FX) / 100;
    end
    if (hue < 0) hue += TURN_FX;
    else if (hue >= TURN_FX) hue -= TURN_FX;
    if (val < 0) val = 0;
    if (val > ONE_FX) val = ONE_FX;
    if (sat < 0) sat = 0;
    if (sat > ONE_FX) sat = ONE_FX;
    top = (val * 255) >>> 16;
    if (sat == 0) begin
      o.red = top[7:0]; o.green = top[7:0]; o.blue = top[7:0];
    end else begin
      m = hue / SEC_FX;
      rem = hue - m * SEC_FX;
      f = rem / 60;
      a = scale_255(val, ONE_FX - sat);
      bb = scale_255(val, ONE_FX - ((sat * f) >>> 16));
      c = scale_255(val, ONE_FX - ((sat * (ONE_FX - f)) >>> 16));
      case (m)
        0: begin o.red = top[7:0]; o.green = c[7:0]; o.blue = a[7:0]; end
        1: begin o.red = bb[7:0]; o.green = top[7:0]; o.blue = a[7:0]; end
        2: begin o.red = a[7:0]; o.green = top[7:0]; o.blue = c[7:0]; end
        3: begin o.red = a[7:0]; o.green = bb[7:0]; o.blue = top[7:0]; end
        4: begin o.red = c[7:0]; o.green = a[7:0]; o.blue = top[7:0]; end
        default: begin o.red = top[7:0]; o.green = a[7:0]; o.blue = bb[7:0]; end
      endcase
    end
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("hsv_color_adjust regression: fail");
      $finish;
    end
    if (!rst) begin
      if (push && !full) begin
        expected_pixels.push_back(adjust_pixel({red_in, green_in, blue_in}));
        pixels_sent <= pixels_sent + 1;
      end
      if (!(push && full)) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel_t nxt;
          nxt = pending_pixels.pop_front();
          push <= 1'b1;
          red_in <= nxt.red;
          green_in <= nxt.green;
          blue_in <= nxt.blue;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected transfer, actual %h %h %h", $time,
                 red_out, green_out, blue_out);
        errors++;
      end else begin
        pixel_t e;
        e = expected_pixels.pop_front();
        if (e.red !== red_out)
          $display("%0t: red expected %0d actual %0d", $time, e.red, red_out);
        if (e.green !== green_out)
          $display("%0t: green expected %0d actual %0d", $time, e.green, green_out);
        if (e.blue !== blue_out)
          $display("%0t: blue expected %0d actual %0d", $time, e.blue, blue_out);
        if (e !== {red_out, green_out, blue_out}) errors++;
        pixels_checked++;
      end
    end
  end

  task automatic wait_drained();
    while (pending_pixels.size() > 0 || push || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_shift(cfg_reg_t idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HUE: hue_offset = data;
      REG_SAT: sat_offset = data[6:0];
      REG_VAL: val_offset = data[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_shifts(logic [8:0] h, logic [6:0] s, logic [6:0] v);
    write_shift(REG_HUE, h);
    write_shift(REG_SAT, {2'b00, s});
    write_shift(REG_VAL, {2'b00, v});
  endtask

  task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pending_pixels.push_back({r, g, b});
  endtask

  task automatic queue_random(int n);
    repeat (n) begin
      case ($urandom_range(3))
        0: queue_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        1: begin
          logic [7:0] v;
          v = 8'($urandom);
          queue_pixel(v, v, v);
        end
        2: begin
          logic [7:0] v;
          v = 8'($urandom);
          queue_pixel(v, $urandom_range(1) ? v : 8'($urandom), v);
        end
        default: queue_pixel($urandom_range(1) ? 8'hff : 8'h00, 8'($urandom),
                             $urandom_range(1) ? 8'hff : 8'h00);
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(128, 128, 128);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 255, 0);
    queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 255);
    queue_pixel(200, 200, 10);
    queue_pixel(10, 200, 200);
    queue_pixel(200, 10, 200);
    queue_pixel(1, 0, 0);
    queue_pixel(255, 254, 0);
    queue_pixel(170, 85, 0);
    wait_drained();

    set_shifts(9'sd180, 7'sd50, 7'sd50);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(128, 128, 128);
    queue_pixel(255, 255, 255);
    queue_random(20);
    wait_drained();
    set_shifts(-9'sd180, -7'sd50, -7'sd50);
    queue_pixel(0, 255, 255);
    queue_pixel(40, 40, 40);
    queue_random(20);
    wait_drained();
    // outside the stated range, with the hue, saturation and value register extremes
    set_shifts(9'h100, 7'h40, 7'h3f);
    queue_random(30);
    wait_drained();
    set_shifts(9'h0ff, 7'h3f, 7'h40);
    queue_pixel(255, 0, 0);
    queue_random(30);
    wait_drained();
    set_shifts(9'sd60, 7'sd0, 7'sd0);
    queue_pixel(255, 0, 255);
    queue_pixel(255, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 71; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 71; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      set_shifts(9'($urandom), 7'($urandom), 7'($urandom));
      queue_random(110);
      while (pending_pixels.size() > 0) @(posedge clk);
      // hold off until the pipeline has drained
      while (push || expected_pixels.size() > 0) @(posedge clk);
      queue_random(110);
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_shifts(9'sd0, 7'sd0, 7'sd0);
    queue_random(20);
    wait_drained();

    $display("covered %0d pixels sent, %0d checked, over gray, tied and saturated colors",
             pixels_sent, pixels_checked);
    $display("shift settings included both range ends and out-of-range register values");
    if (errors == 0) begin
      $display("hsv_color_adjust regression: pass");
    end else begin
      $display("hsv_color_adjust regression: fail");
    end
    $finish;
  end
endmodule
